// File: hw/rtl/dlt_pkg.sv
// dlt_pkg: shared types and codes for the delta list timer queue
// holds command codes, result kinds and the control/status structs
// used between dlt_ctrl and dlt_datapath; no dependencies
package dlt_pkg;

  // input command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // result kinds
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_INS_INIT_CMD,
    OP_INS_INIT_RELOAD,
    OP_RD_POS,
    OP_INS_STEP,
    OP_INS_FINISH,
    OP_STOP_INIT,
    OP_STOP_STEP,
    OP_RD_NEXT,
    OP_REM_MOVE,
    OP_REM_FINISH,
    OP_TICK_INIT,
    OP_RD_HEAD,
    OP_TICK_EVAL,
    OP_TICK_LAST,
    OP_ACK
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   ack_ign;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       id_ok;
    logic       id_active;
    logic       len_zero;
    logic       pos_at_end;
    logic       pos_next_lt;
    logic       match;
    logic       head_zero;
    logic       reload;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/dlt_ram.sv
// dlt_ram: generic simple dual port ram, one write and one read port
// read data is registered and holds while rd_en is low
// no dependencies
module dlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/dlt_ctrl.sv
// dlt_ctrl: sequencer for the delta list timer queue
// walks start, stop and tick requests through datapath micro-operations
// depends on dlt_pkg
module dlt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dlt_pkg::dp_stat_t  stat,
  output dlt_pkg::dp_cmd_t   ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_CMP,
    S_STOP_CHK,
    S_STOP_CMP,
    S_REM_CHK,
    S_REM_MOVE,
    S_RELOAD,
    S_TICK_CHK,
    S_TICK_EVAL,
    S_ACK
  } state_t;

  state_t          state, state_next;
  logic            ack_ign, ack_ign_next;
  dlt_pkg::dp_op_t op;
  logic            is_tick;

  assign is_tick  = (stat.cmd == dlt_pkg::CMD_TICK);
  assign in_ready = (state == S_IDLE);
  assign ctl.op      = op;
  assign ctl.ack_ign = ack_ign;

  // next state and micro-operation
  always_comb begin
    state_next   = state;
    ack_ign_next = ack_ign;
    op           = dlt_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = dlt_pkg::OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (stat.cmd)
          dlt_pkg::CMD_TICK: begin
            if (stat.len_zero) begin
              state_next = S_IDLE;
            end else begin
              op         = dlt_pkg::OP_TICK_INIT;
              state_next = S_TICK_CHK;
            end
          end
          dlt_pkg::CMD_START: begin
            if (!stat.id_ok || stat.id_active) begin
              ack_ign_next = 1'b1;
              state_next   = S_ACK;
            end else begin
              ack_ign_next = 1'b0;
              op           = dlt_pkg::OP_INS_INIT_CMD;
              state_next   = S_INS_CHK;
            end
          end
          dlt_pkg::CMD_STOP: begin
            if (!stat.id_ok || !stat.id_active) begin
              ack_ign_next = 1'b1;
              state_next   = S_ACK;
            end else begin
              ack_ign_next = 1'b0;
              op           = dlt_pkg::OP_STOP_INIT;
              state_next   = S_STOP_CHK;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.pos_at_end) begin
          op         = dlt_pkg::OP_INS_FINISH;
          state_next = is_tick ? S_TICK_CHK : S_ACK;
        end else begin
          op         = dlt_pkg::OP_RD_POS;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        op         = dlt_pkg::OP_INS_STEP;
        state_next = S_INS_CHK;
      end
      S_STOP_CHK: begin
        op         = dlt_pkg::OP_RD_POS;
        state_next = S_STOP_CMP;
      end
      S_STOP_CMP: begin
        op         = dlt_pkg::OP_STOP_STEP;
        state_next = stat.match ? S_REM_CHK : S_STOP_CHK;
      end
      S_REM_CHK: begin
        if (stat.pos_next_lt) begin
          op         = dlt_pkg::OP_RD_NEXT;
          state_next = S_REM_MOVE;
        end else begin
          op         = dlt_pkg::OP_REM_FINISH;
          state_next = is_tick ? S_RELOAD : S_ACK;
        end
      end
      S_REM_MOVE: begin
        op         = dlt_pkg::OP_REM_MOVE;
        state_next = S_REM_CHK;
      end
      S_RELOAD: begin
        if (stat.reload) begin
          op         = dlt_pkg::OP_INS_INIT_RELOAD;
          state_next = S_INS_CHK;
        end else begin
          state_next = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (stat.len_zero) begin
          // list ran empty, the pending expiry is the final one
          if (stat.out_free) begin
            op         = dlt_pkg::OP_TICK_LAST;
            state_next = S_IDLE;
          end
        end else begin
          op         = dlt_pkg::OP_RD_HEAD;
          state_next = S_TICK_EVAL;
        end
      end
      S_TICK_EVAL: begin
        if (stat.out_free) begin
          op         = dlt_pkg::OP_TICK_EVAL;
          state_next = stat.head_zero ? S_REM_CHK : S_IDLE;
        end
      end
      S_ACK: begin
        if (stat.out_free) begin
          op         = dlt_pkg::OP_ACK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ack_ign <= 1'b0;
    end else begin
      state   <= state_next;
      ack_ign <= ack_ign_next;
    end
  end

  // a request is latched only from idle
  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    (op == dlt_pkg::OP_LATCH) |-> (state == S_IDLE && in_valid))
    else $error("request latched outside idle");

  // a dispatch always follows a latch
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    (op == dlt_pkg::OP_LATCH) |=> (state == S_DISPATCH))
    else $error("latch not followed by dispatch");

  // a stop search only runs for a timer that is running
  a_stop_active: assert property (@(posedge clk) disable iff (rst)
    (op == dlt_pkg::OP_STOP_INIT) |-> (stat.id_ok && stat.id_active))
    else $error("stop search started for idle timer");

endmodule

// File: hw/rtl/dlt_datapath.sv
// dlt_datapath: delta list storage, per-timer settings, walk registers
// and the output register of the delta list timer queue
// depends on dlt_pkg and dlt_ram
module dlt_datapath #(
  parameter int NUM_TIMERS  = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dlt_pkg::dp_cmd_t  ctl,
  output dlt_pkg::dp_stat_t stat,
  input  logic [1:0]        in_cmd,
  input  logic [3:0]        in_id,
  input  logic [15:0]       in_period,
  input  logic              in_reload,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [3:0]        out_id,
  output logic              out_ign,
  output logic              out_last
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);
  localparam int PB = PERIOD_BITS;
  localparam int EW = IW + PB;
  localparam int XW = (PB > 16) ? PB : 16;

  // latched request
  logic [1:0]    cmd_q;
  logic [3:0]    id_q;
  logic [PB-1:0] per_q;
  logic          rel_q;

  // list state and walk registers
  logic [NUM_TIMERS-1:0] active;
  logic [LW-1:0]         len;
  logic [LW-1:0]         pos;
  logic [PB-1:0]         d;
  logic                  found;
  logic [EW-1:0]         held;
  logic [IW-1:0]         cur_t;
  logic [PB-1:0]         add_d;
  logic                  first;
  logic                  decr;
  logic                  pend;

  // entry ram ports
  logic          e_we, e_re;
  logic [IW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic [IW-1:0] rd_t;
  logic [PB-1:0] rd_dl;

  // timer settings ram ports
  logic          t_we;
  logic [PB:0]   t_rdata;

  // derived values
  logic [XW-1:0] per_x, pmax_x, per_sat;
  logic [IW-1:0] id_idx;
  logic [PB-1:0] hd;
  logic          head_zero, ge, match, out_free, emit;
  logic          emit_kind, emit_last;
  logic [3:0]    emit_id;

  assign rd_t  = e_rdata[EW-1:PB];
  assign rd_dl = e_rdata[PB-1:0];

  // period clamp: zero becomes one, wide values saturate
  assign per_x   = XW'(in_period);
  assign pmax_x  = XW'({PB{1'b1}});
  assign per_sat = (per_x == '0) ? XW'(1) : ((per_x > pmax_x) ? pmax_x : per_x);

  assign id_idx    = IW'(id_q);
  assign hd        = (decr && rd_dl != '0) ? rd_dl - PB'(1) : rd_dl;
  assign head_zero = (hd == '0);
  assign ge        = (d >= rd_dl);
  assign match     = (rd_t == cur_t);
  assign out_free  = !out_valid || out_ready;

  // status to the controller
  assign stat.cmd         = cmd_q;
  assign stat.id_ok       = (int'(id_q) < NUM_TIMERS);
  assign stat.id_active   = active[id_idx];
  assign stat.len_zero    = (len == '0);
  assign stat.pos_at_end  = (pos == len);
  assign stat.pos_next_lt = ((pos + LW'(1)) < len);
  assign stat.match       = match;
  assign stat.head_zero   = head_zero;
  assign stat.reload      = t_rdata[PB];
  assign stat.out_free    = out_free;

  // entry ram access per micro-operation
  always_comb begin
    e_we    = 1'b0;
    e_re    = 1'b0;
    e_waddr = pos[IW-1:0];
    e_raddr = pos[IW-1:0];
    e_wdata = held;
    unique case (ctl.op)
      dlt_pkg::OP_RD_POS: begin
        e_re = 1'b1;
      end
      dlt_pkg::OP_RD_NEXT: begin
        e_re    = 1'b1;
        e_raddr = IW'(pos + LW'(1));
      end
      dlt_pkg::OP_RD_HEAD: begin
        e_re    = 1'b1;
        e_raddr = '0;
      end
      dlt_pkg::OP_INS_STEP: begin
        if (found) begin
          e_we = 1'b1;
        end else if (!ge) begin
          e_we    = 1'b1;
          e_wdata = {cur_t, d};
        end
      end
      dlt_pkg::OP_INS_FINISH: begin
        e_we    = 1'b1;
        e_waddr = len[IW-1:0];
        e_wdata = found ? held : {cur_t, d};
      end
      dlt_pkg::OP_REM_MOVE: begin
        e_we    = 1'b1;
        e_wdata = {rd_t, rd_dl + (first ? add_d : PB'(0))};
      end
      dlt_pkg::OP_TICK_EVAL: begin
        // head survives the tick: write back its decremented delta
        if (!head_zero && decr) begin
          e_we    = 1'b1;
          e_waddr = '0;
          e_wdata = {rd_t, hd};
        end
      end
      default: begin
      end
    endcase
  end

  assign t_we = (ctl.op == dlt_pkg::OP_INS_INIT_CMD);

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_kind = dlt_pkg::KIND_EXPIRE;
    emit_id   = 4'(cur_t);
    emit_last = 1'b1;
    unique case (ctl.op)
      dlt_pkg::OP_TICK_EVAL: begin
        emit      = pend;
        emit_last = !head_zero;
      end
      dlt_pkg::OP_TICK_LAST: begin
        emit = 1'b1;
      end
      dlt_pkg::OP_ACK: begin
        emit      = 1'b1;
        emit_kind = dlt_pkg::KIND_ACK;
        emit_id   = id_q;
      end
      default: begin
      end
    endcase
  end

  dlt_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS)) u_entry_ram (
    .clk     (clk),
    .wr_en   (e_we),
    .wr_addr (e_waddr),
    .wr_data (e_wdata),
    .rd_en   (e_re),
    .rd_addr (e_raddr),
    .rd_data (e_rdata)
  );

  dlt_ram #(.WIDTH(PB + 1), .DEPTH(NUM_TIMERS)) u_timer_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (id_idx),
    .wr_data ({rel_q, per_q}),
    .rd_en   (1'b1),
    .rd_addr (cur_t),
    .rd_data (t_rdata)
  );

  // walk registers, list state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      len       <= '0;
      found     <= 1'b0;
      first     <= 1'b0;
      decr      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_kind  <= emit_kind;
        out_id    <= emit_id;
        out_ign   <= (ctl.op == dlt_pkg::OP_ACK) ? ctl.ack_ign : 1'b0;
        out_last  <= emit_last;
      end
      unique case (ctl.op)
        dlt_pkg::OP_LATCH: begin
          cmd_q <= in_cmd;
          id_q  <= in_id;
          per_q <= PB'(per_sat);
          rel_q <= in_reload;
        end
        dlt_pkg::OP_INS_INIT_CMD: begin
          cur_t <= id_idx;
          d     <= per_q;
          pos   <= '0;
          found <= 1'b0;
        end
        dlt_pkg::OP_INS_INIT_RELOAD: begin
          d     <= t_rdata[PB-1:0];
          pos   <= '0;
          found <= 1'b0;
        end
        dlt_pkg::OP_INS_STEP: begin
          pos <= pos + LW'(1);
          if (found) begin
            held <= e_rdata;
          end else if (ge) begin
            d <= d - rd_dl;
          end else begin
            // new entry goes here, successor's delta drops by the new delta
            held  <= {rd_t, rd_dl - d};
            found <= 1'b1;
          end
        end
        dlt_pkg::OP_INS_FINISH: begin
          len           <= len + LW'(1);
          active[cur_t] <= 1'b1;
        end
        dlt_pkg::OP_STOP_INIT: begin
          cur_t <= id_idx;
          pos   <= '0;
        end
        dlt_pkg::OP_STOP_STEP: begin
          if (match) begin
            add_d <= rd_dl;
            first <= 1'b1;
          end else begin
            pos <= pos + LW'(1);
          end
        end
        dlt_pkg::OP_REM_MOVE: begin
          first <= 1'b0;
          pos   <= pos + LW'(1);
        end
        dlt_pkg::OP_REM_FINISH: begin
          len           <= len - LW'(1);
          active[cur_t] <= 1'b0;
        end
        dlt_pkg::OP_TICK_INIT: begin
          decr <= 1'b1;
          pend <= 1'b0;
        end
        dlt_pkg::OP_TICK_EVAL: begin
          decr <= 1'b0;
          pend <= head_zero;
          if (head_zero) begin
            cur_t <= rd_t;
            pos   <= '0;
            add_d <= '0;
            first <= 1'b0;
          end
        end
        dlt_pkg::OP_TICK_LAST: begin
          pend <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // between requests every running timer has exactly one list entry
  a_len_active: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == dlt_pkg::OP_LATCH) |-> ($countones(active) == int'(len)))
    else $error("list length differs from running timer count");

  // results only go into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote a waiting result");

  // list length only moves on insert or remove completion
  a_len_stable: assert property (@(posedge clk) disable iff (rst)
    (ctl.op != dlt_pkg::OP_INS_FINISH && ctl.op != dlt_pkg::OP_REM_FINISH)
      |=> $stable(len))
    else $error("list length changed outside insert or remove");

endmodule

// File: hw/rtl/delta_list_timer_queue.sv
// delta_list_timer_queue: top level of the delta list timer queue
// joins the dlt_ctrl sequencer and the dlt_datapath list engine
// depends on dlt_pkg, dlt_ctrl, dlt_datapath
//
//   channel  dir  handshake                 payload
//   s        in   s_tvalid / s_tready       s_tdata, s_tuser (cmd)
//   m        out  m_tvalid / m_tready       m_tdata, m_tuser (kind), m_tlast
//
// one request at a time; the entry memory is walked one entry per step
// (registered read then compare and write); starts, stops and ticks walk it,
// and a tick walks it again for each expired timer and its reload insert
// reset empties the list and stops every timer at once, no clearing pass
// results go through an output register; the block stalls when an ack or a
// tick result step meets a full output register
module delta_list_timer_queue #(
  parameter int NUM_TIMERS  = 16,
  parameter int PERIOD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // timer_id[3:0], period[19:4], reload[20], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // timer_id_res[3:0], ignored[4], zero pad
  output logic [0:0]  m_tuser,   // kind[0]
  output logic        m_tlast
);

  dlt_pkg::dp_cmd_t  ctl;
  dlt_pkg::dp_stat_t stat;
  logic [3:0]        res_id;
  logic              res_ign;
  logic              res_kind;

  dlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  dlt_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .in_cmd    (s_tuser),
    .in_id     (s_tdata[3:0]),
    .in_period (s_tdata[19:4]),
    .in_reload (s_tdata[20]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (res_kind),
    .out_id    (res_id),
    .out_ign   (res_ign),
    .out_last  (m_tlast)
  );

  // result packing
  assign m_tdata = {3'b000, res_ign, res_id};
  assign m_tuser = res_kind;

endmodule
